@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by min_tracking_stack.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// Minimum tracking stack package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 6;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_POP_LOAD
	} state_t;

	typedef struct packed {
		logic ld_push;
		logic ld_overflow;
		logic ld_underflow;
		logic pop_last;
		logic pop_read;
		logic pop_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic single;
		logic full;
		logic out_busy;
	} sts_t;

endpackage

@@ design/mts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/mts_ctrl.sv @@
// ----------------------------------------------------------------------------
// Minimum tracking stack controller
// Accepts one transaction at a time and sequences the datapath commands.
// ----------------------------------------------------------------------------
module mts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          operation,
	input  mts_pkg::sts_t sts,
	output mts_pkg::cmd_t cmd
);
	import mts_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		accept    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !sts.out_busy;
				accept   = in_valid && !sts.out_busy;
				if (accept) begin
					if (operation == OP_PUSH) begin
						if (sts.full) begin
							cmd.ld_overflow = 1'b1;
						end else begin
							cmd.ld_push = 1'b1;
						end
					end else begin
						priority if (sts.empty) begin
							cmd.ld_underflow = 1'b1;
						end else if (sts.single) begin
							cmd.pop_last = 1'b1;
						end else begin
							cmd.pop_read = 1'b1;
							state_nxt    = S_POP_LOAD;
						end
					end
				end
			end
			S_POP_LOAD: begin
				cmd.pop_load = 1'b1;
				state_nxt    = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/mts_dp.sv @@
// ----------------------------------------------------------------------------
// Minimum tracking stack datapath
// Top entry registers, entry store, fill count, limit register and result
// register.
// ----------------------------------------------------------------------------
module mts_dp #(
	parameter int DEPTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mts_pkg::CNT_W-1:0]         cfg_wdata,
	input  logic signed [mts_pkg::DATA_W-1:0] push_value,
	input  mts_pkg::cmd_t                     cmd,
	output mts_pkg::sts_t                     sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [mts_pkg::DATA_W-1:0] popped_value,
	output logic signed [mts_pkg::DATA_W-1:0] current_min,
	output logic                              stack_empty,
	output logic [mts_pkg::CNT_W-1:0]         entry_count
);
	import mts_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int DW = $clog2(DEPTH + 1);
	localparam int XW = (DW > CNT_W) ? DW : CNT_W;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         limit_q;
	logic signed [DATA_W-1:0] top_val_q;
	logic signed [DATA_W-1:0] top_min_q;
	logic signed [DATA_W-1:0] pop_val_q;
	logic signed [DATA_W-1:0] new_min;
	logic signed [DATA_W-1:0] rd_val;
	logic signed [DATA_W-1:0] rd_min;
	logic [2*DATA_W-1:0]      rdata;
	logic                     ram_we;
	logic                     load;

	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic signed [DATA_W-1:0] popped_q;
	logic signed [DATA_W-1:0] min_q;
	logic                     empty_q;
	logic [CNT_W-1:0]         count_out_q;

	logic [1:0]               status_nxt;
	logic signed [DATA_W-1:0] popped_nxt;
	logic signed [DATA_W-1:0] min_nxt;
	logic [CNT_W-1:0]         count_nxt;

	assign rd_val = rdata[2*DATA_W-1:DATA_W];
	assign rd_min = rdata[DATA_W-1:0];
	assign ram_we = cmd.ld_push && (count_q != '0);

	assign new_min = ((count_q != '0) && !(push_value < top_min_q)) ? top_min_q : push_value;

	assign sts.empty    = (count_q == '0);
	assign sts.single   = (count_q == CNT_W'(1));
	assign sts.full     = (count_q >= limit_q) || (XW'(count_q) >= XW'(DEPTH));
	assign sts.out_busy = out_valid_q && !out_ready;

	mts_ram #(
		.WIDTH(2 * DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(count_q - CNT_W'(1))),
		.wdata({top_val_q, top_min_q}),
		.re   (cmd.pop_read),
		.raddr(AW'(count_q - CNT_W'(2))),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.ld_push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop_last || cmd.pop_read) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_push) begin
			top_val_q <= push_value;
			top_min_q <= new_min;
		end else if (cmd.pop_load) begin
			top_val_q <= rd_val;
			top_min_q <= rd_min;
		end
		if (cmd.pop_read) begin
			pop_val_q <= top_val_q;
		end
	end

	always_comb begin
		load       = 1'b1;
		status_nxt = ST_OK;
		popped_nxt = '0;
		min_nxt    = '0;
		count_nxt  = count_q;
		priority if (cmd.ld_push) begin
			min_nxt   = new_min;
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd.ld_overflow) begin
			status_nxt = ST_OVERFLOW;
			min_nxt    = (count_q != '0) ? top_min_q : '0;
		end else if (cmd.ld_underflow) begin
			status_nxt = ST_UNDERFLOW;
		end else if (cmd.pop_last) begin
			popped_nxt = top_val_q;
			count_nxt  = '0;
		end else if (cmd.pop_load) begin
			popped_nxt = pop_val_q;
			min_nxt    = rd_min;
		end else begin
			load = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q    <= status_nxt;
			popped_q    <= popped_nxt;
			min_q       <= min_nxt;
			empty_q     <= (count_nxt == '0);
			count_out_q <= count_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign current_min  = min_q;
	assign stack_empty  = empty_q;
	assign entry_count  = count_out_q;

endmodule

@@ design/min_tracking_stack.sv @@
// ----------------------------------------------------------------------------
// Minimum tracking stack
// Push: result valid in the cycle after the transaction is accepted.
// Pop leaving entries: entry store read registered, then loaded in S_POP_LOAD.
// Other pops and refused operations: next cycle. One transaction at a time.
// Reset (arst_n low) empties the stack and sets the limit to 32.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_tracking_stack #(
	parameter int DEPTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mts_pkg::CNT_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic signed [mts_pkg::DATA_W-1:0] push_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [mts_pkg::DATA_W-1:0] popped_value,
	output logic signed [mts_pkg::DATA_W-1:0] current_min,
	output logic                              stack_empty,
	output logic [mts_pkg::CNT_W-1:0]         entry_count
);
	import mts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.sts      (sts),
		.cmd      (cmd)
	);

	mts_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.push_value  (push_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.popped_value(popped_value),
		.current_min (current_min),
		.stack_empty (stack_empty),
		.entry_count (entry_count)
	);

	`ASSERT_IMPLIES(a_no_accept_when_blocked, clk, arst_n, in_valid && in_ready, !(out_valid && !out_ready))
	`ASSERT_IMPLIES(a_empty_result, clk, arst_n, out_valid && stack_empty, (current_min == '0) && (entry_count == '0))
	`ASSERT_IMPLIES(a_underflow_result, clk, arst_n, out_valid && (status == ST_UNDERFLOW), stack_empty && (popped_value == '0))
	`ASSERT_NEXT(a_pop_load_follows, clk, arst_n, cmd.pop_read, cmd.pop_load && !in_ready)

endmodule
